// ===== hdl/sdci_pkg.sv =====
// ----------------------------------------------------------------------------
// sdci_pkg
// Types, codes and helper functions of the SD/MMC card identification
// sequencer.
// ----------------------------------------------------------------------------
package sdci_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_HOST_DATA_LINES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCR_WINDOW      = 1'd1;

	localparam logic [3:0]  HOST_LINES_RESET = 4'd1;
	localparam logic [23:0] OCR_WINDOW_RESET = 24'hFF8000;

	localparam logic [1:0] ACT_ISSUE   = 2'd0;
	localparam logic [1:0] ACT_DONE    = 2'd1;
	localparam logic [1:0] ACT_FAILED  = 2'd2;
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam logic [2:0] RK_NONE = 3'd0;
	localparam logic [2:0] RK_R1   = 3'd1;
	localparam logic [2:0] RK_R1B  = 3'd2;
	localparam logic [2:0] RK_R2   = 3'd3;
	localparam logic [2:0] RK_R3   = 3'd4;
	localparam logic [2:0] RK_R6   = 3'd5;

	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
	localparam logic [2:0] TYPE_MMC     = 3'd1;
	localparam logic [2:0] TYPE_SDV1    = 3'd2;
	localparam logic [2:0] TYPE_SDV2    = 3'd3;
	localparam logic [2:0] TYPE_SDHC    = 3'd4;

	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_SEND_OP    = 6'd1;
	localparam logic [5:0] CMD_ALL_CID    = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
	localparam logic [5:0] CMD_BUS_WIDTH  = 6'd6;
	localparam logic [5:0] CMD_SELECT     = 6'd7;
	localparam logic [5:0] CMD_IF_COND    = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
	localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
	localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
	localparam logic [5:0] CMD_APP        = 6'd55;

	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_OCR_DEF  = 32'h00FF_8000;
	localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
	localparam logic [31:0] ARG_BLOCKLEN = 32'd512;
	localparam logic [31:0] ARG_WIDE_BUS = 32'd2;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_CMD0    = 4'd1,
		PH_CMD8    = 4'd2,
		PH_V2POLL  = 4'd3,
		PH_PROBE   = 4'd4,
		PH_V1POLL  = 4'd5,
		PH_MMCPOLL = 4'd6,
		PH_CMD2    = 4'd7,
		PH_CMD3    = 4'd8,
		PH_CMD9    = 4'd9,
		PH_CMD7    = 4'd10,
		PH_CMD16   = 4'd11,
		PH_ACMD6   = 4'd12
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic        cmd_failed;
		logic [63:0] resp_high;
		logic [63:0] resp_low;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic [2:0]  resp_kind;
		logic        wait_first;
		logic        wide_bus_ok;
		logic [2:0]  card_type;
		logic [15:0] card_address;
		logic [32:0] capacity_sectors;
		logic [19:0] max_speed;
	} out_item_t;

	function automatic logic [6:0] speed_mantissa(input logic [3:0] code);
		logic [6:0] v;
		unique case (code)
			4'd0:    v = 7'd0;
			4'd1:    v = 7'd10;
			4'd2:    v = 7'd12;
			4'd3:    v = 7'd13;
			4'd4:    v = 7'd15;
			4'd5:    v = 7'd20;
			4'd6:    v = 7'd25;
			4'd7:    v = 7'd30;
			4'd8:    v = 7'd35;
			4'd9:    v = 7'd40;
			4'd10:   v = 7'd45;
			4'd11:   v = 7'd50;
			4'd12:   v = 7'd55;
			4'd13:   v = 7'd60;
			4'd14:   v = 7'd70;
			default: v = 7'd80;
		endcase
		return v;
	endfunction

	// Unit codes above three are taken as the lowest unit.
	function automatic logic [19:0] speed_of(input logic [7:0] tran_speed);
		logic [13:0] unit;
		logic [20:0] prod;
		unique case (tran_speed[2:0])
			3'd1:    unit = 14'd100;
			3'd2:    unit = 14'd1000;
			3'd3:    unit = 14'd10000;
			default: unit = 14'd10;
		endcase
		prod = 21'(speed_mantissa(tran_speed[6:3])) * 21'(unit);
		return prod[19:0];
	endfunction

	function automatic logic [32:0] capacity_of(input logic [63:0] csd_hi,
			input logic [63:0] csd_lo, input logic block_addr);
		logic [7:0]  b5, b6, b7, b8, b9, b10;
		logic [4:0]  sh;
		logic [12:0] cs;
		logic [22:0] cs_hc;
		logic [32:0] res;
		b5    = csd_hi[23:16];
		b6    = csd_hi[15:8];
		b7    = csd_hi[7:0];
		b8    = csd_lo[63:56];
		b9    = csd_lo[55:48];
		b10   = csd_lo[47:40];
		sh    = 5'(b5[3:0]) + 5'(b10[7]) + {2'b00, b9[1:0], 1'b0} + 5'd2;
		cs    = 13'(b8[7:6]) + {3'b000, b7, 2'b00} + {1'b0, b6[1:0], 10'd0} + 13'd1;
		cs_hc = 23'({b7[5:0], b8, b9}) + 23'd1;
		if (block_addr) begin
			res = {cs_hc, 10'd0};
		end else if (sh >= 5'd9) begin
			res = 33'(cs) << (sh - 5'd9);
		end else begin
			res = 33'(cs) >> (5'd9 - sh);
		end
		return res;
	endfunction

endpackage

// ===== hdl/sd_card_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// Host-side SD/MMC card identification sequencer: answers each start or
// command completion with the next command to send, or with done, failed or ignored.
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid / in_ready    | in_data (in_item_t)
//   out     | source    | out_valid / out_ready  | out_data (out_item_t)
//   cfg     | sink      | cfg_write              | cfg_index, cfg_data
//
// Every beat passes through the input register; its reply is then decided
// and registered into the result register.
// A new beat is taken every cycle while the result register drains.
// A stalled result holds the input register, which then stops further beats.
// Reset clears the phase to idle and the card type, address and flags to zero.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer
	import sdci_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_data_q;
	logic        advance;

	logic [3:0]  host_lines_q;
	logic [23:0] ocr_window_q;

	phase_t      phase_q, phase_d;
	logic        app_q, app_d;
	logic [2:0]  type_q, type_d;
	logic [15:0] rca_q, rca_d;
	logic        wide_q, wide_d;
	logic [63:0] csd_hi_q, csd_lo_q;
	logic        csd_we;
	out_item_t   res;

	logic        start, bad, is_sd, wide_host, v2_match, cmd16_bad;
	logic [7:0]  b0, b1, b2, b3;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign start     = !item_s1.kind;
	assign bad       = item_s1.cmd_failed;
	assign b0        = item_s1.resp_high[63:56];
	assign b1        = item_s1.resp_high[55:48];
	assign b2        = item_s1.resp_high[47:40];
	assign b3        = item_s1.resp_high[39:32];
	assign is_sd     = (type_q == TYPE_SDV1) || (type_q == TYPE_SDV2) || (type_q == TYPE_SDHC);
	assign wide_host = host_lines_q >= 4'd4;
	assign v2_match  = !bad && (b2[3:0] == 4'd1) && (b3 == 8'hAA);
	assign cmd16_bad = bad || ((b0 & 8'hFD) != 8'd0) || ((b1 & 8'hF9) != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_lines_q <= HOST_LINES_RESET;
			ocr_window_q <= OCR_WINDOW_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HOST_DATA_LINES: host_lines_q <= cfg_data[3:0];
				REG_OCR_WINDOW:      ocr_window_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (start) begin
			phase_d = PH_CMD0;
		end else begin
			unique case (phase_q)
				PH_CMD0: phase_d = PH_CMD8;
				PH_CMD8: phase_d = v2_match ? PH_V2POLL : PH_PROBE;
				PH_PROBE: begin
					if (bad) begin
						phase_d = PH_MMCPOLL;
					end else if (!app_q) begin
						phase_d = PH_V1POLL;
					end
				end
				PH_V2POLL, PH_V1POLL: begin
					if (bad) begin
						phase_d = PH_IDLE;
					end else if (!app_q && b0[7]) begin
						phase_d = PH_CMD2;
					end
				end
				PH_MMCPOLL: begin
					if (bad) begin
						phase_d = PH_IDLE;
					end else if (b0[7]) begin
						phase_d = PH_CMD2;
					end
				end
				PH_CMD2: phase_d = bad ? PH_IDLE : PH_CMD3;
				PH_CMD3: phase_d = bad ? PH_IDLE : PH_CMD9;
				PH_CMD9: phase_d = bad ? PH_IDLE : PH_CMD7;
				PH_CMD7: begin
					if (bad) begin
						phase_d = PH_IDLE;
					end else if (type_q != TYPE_SDHC) begin
						phase_d = PH_CMD16;
					end else begin
						phase_d = (is_sd && wide_host) ? PH_ACMD6 : PH_IDLE;
					end
				end
				PH_CMD16: begin
					if (cmd16_bad) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = (is_sd && wide_host) ? PH_ACMD6 : PH_IDLE;
					end
				end
				PH_ACMD6: phase_d = (app_q && !bad) ? PH_ACMD6 : PH_IDLE;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		res          = '0;
		res.action   = ACT_ISSUE;
		app_d        = app_q;
		type_d       = type_q;
		rca_d        = rca_q;
		wide_d       = wide_q;
		csd_we       = 1'b0;
		if (start) begin
			app_d         = 1'b0;
			type_d        = TYPE_UNKNOWN;
			rca_d         = 16'd0;
			wide_d        = 1'b0;
			res.cmd_index = CMD_GO_IDLE;
			res.resp_kind = RK_NONE;
		end else begin
			unique case (phase_q)
				PH_CMD0: begin
					res.cmd_index    = CMD_IF_COND;
					res.cmd_argument = ARG_IF_COND;
					res.resp_kind    = RK_R1;
					res.wait_first   = 1'b1;
				end
				PH_CMD8: begin
					app_d            = 1'b1;
					res.cmd_index    = CMD_APP;
					res.cmd_argument = {rca_q, 16'd0};
					res.resp_kind    = RK_R1;
				end
				PH_PROBE: begin
					if (app_q && !bad) begin
						app_d            = 1'b0;
						res.cmd_index    = CMD_SD_OP_COND;
						res.cmd_argument = ARG_OCR_DEF;
						res.resp_kind    = RK_R3;
					end else if (bad) begin
						app_d            = 1'b0;
						type_d           = TYPE_MMC;
						res.cmd_index    = CMD_SEND_OP;
						res.cmd_argument = ARG_OCR_DEF;
						res.resp_kind    = RK_R3;
					end else begin
						app_d            = 1'b1;
						type_d           = TYPE_SDV1;
						res.cmd_index    = CMD_APP;
						res.cmd_argument = {rca_q, 16'd0};
						res.resp_kind    = RK_R1;
					end
				end
				PH_V2POLL, PH_V1POLL: begin
					if (bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else if (app_q) begin
						app_d            = 1'b0;
						res.cmd_index    = CMD_SD_OP_COND;
						res.cmd_argument = (phase_q == PH_V2POLL) ?
							(ARG_HCS | {8'd0, ocr_window_q}) : ARG_OCR_DEF;
						res.resp_kind    = RK_R3;
					end else if (b0[7]) begin
						if (phase_q == PH_V2POLL) begin
							type_d = b0[6] ? TYPE_SDHC : TYPE_SDV2;
						end
						res.cmd_index = CMD_ALL_CID;
						res.resp_kind = RK_R2;
					end else begin
						app_d            = 1'b1;
						res.cmd_index    = CMD_APP;
						res.cmd_argument = {rca_q, 16'd0};
						res.resp_kind    = RK_R1;
						res.wait_first   = 1'b1;
					end
				end
				PH_MMCPOLL: begin
					if (bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else if (b0[7]) begin
						res.cmd_index = CMD_ALL_CID;
						res.resp_kind = RK_R2;
					end else begin
						res.cmd_index    = CMD_SEND_OP;
						res.cmd_argument = ARG_OCR_DEF;
						res.resp_kind    = RK_R3;
						res.wait_first   = 1'b1;
					end
				end
				PH_CMD2: begin
					if (bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else begin
						res.cmd_index    = CMD_SEND_RCA;
						res.cmd_argument = is_sd ? 32'd0 : {16'd1, 16'd0};
						res.resp_kind    = RK_R6;
					end
				end
				PH_CMD3: begin
					rca_d = is_sd ? {b0, b1} : 16'd1;
					if (bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else begin
						res.cmd_index    = CMD_SEND_CSD;
						res.cmd_argument = {rca_d, 16'd0};
						res.resp_kind    = RK_R2;
					end
				end
				PH_CMD9: begin
					if (bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else begin
						csd_we           = 1'b1;
						res.cmd_index    = CMD_SELECT;
						res.cmd_argument = {rca_q, 16'd0};
						res.resp_kind    = RK_R1B;
					end
				end
				PH_CMD7, PH_CMD16: begin
					if ((phase_q == PH_CMD7) ? bad : cmd16_bad) begin
						app_d      = 1'b0;
						res.action = ACT_FAILED;
					end else if (phase_q == PH_CMD7 && type_q != TYPE_SDHC) begin
						res.cmd_index    = CMD_BLOCKLEN;
						res.cmd_argument = ARG_BLOCKLEN;
						res.resp_kind    = RK_R1;
					end else if (is_sd && wide_host) begin
						app_d            = 1'b1;
						res.cmd_index    = CMD_APP;
						res.cmd_argument = {rca_q, 16'd0};
						res.resp_kind    = RK_R1;
					end else begin
						app_d      = 1'b0;
						res.action = ACT_DONE;
					end
				end
				PH_ACMD6: begin
					app_d = 1'b0;
					if (app_q) begin
						if (bad) begin
							res.action = ACT_DONE;
						end else begin
							res.cmd_index    = CMD_BUS_WIDTH;
							res.cmd_argument = ARG_WIDE_BUS;
							res.resp_kind    = RK_R1;
						end
					end else begin
						if (!bad && b0[7:6] == 2'b00 && (b1 & 8'h58) == 8'd0) begin
							wide_d = 1'b1;
						end
						res.action = ACT_DONE;
					end
				end
				default: begin
					app_d      = 1'b0;
					res.action = ACT_IGNORED;
				end
			endcase
		end
		res.wide_bus_ok  = wide_d;
		res.card_type    = type_d;
		res.card_address = rca_d;
		if (res.action == ACT_DONE) begin
			res.capacity_sectors = capacity_of(csd_hi_q, csd_lo_q, type_q == TYPE_SDHC);
			res.max_speed        = speed_of(csd_hi_q[39:32]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			app_q   <= 1'b0;
			type_q  <= TYPE_UNKNOWN;
			rca_q   <= 16'd0;
			wide_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			app_q   <= app_d;
			type_q  <= type_d;
			rca_q   <= rca_d;
			wide_q  <= wide_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && csd_we) begin
			csd_hi_q <= item_s1.resp_high;
			csd_lo_q <= item_s1.resp_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SD/MMC card identification sequencer. A
// scoreboard keeps its own copy of the card state and configuration, works
// out the reply to every accepted beat and compares each reply with it. A
// short directed run walks the SDHC path with wide bus and the MMC path;
// random card sessions then follow under several register settings, with
// gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
import sdci_pkg::*;

class init_scoreboard;
	phase_t      ph;
	bit          app_pending;
	logic [2:0]  ctype;
	logic [15:0] rca;
	logic [31:0] ocr;
	logic [63:0] cid [2];
	logic [63:0] csd [2];
	bit          wide;
	logic [3:0]  lines;
	logic [23:0] window;
	out_item_t   replies_due [$];
	int          errors;

	function new();
		lines       = HOST_LINES_RESET;
		window      = OCR_WINDOW_RESET;
		ph          = PH_IDLE;
		app_pending = 0;
		ctype       = TYPE_UNKNOWN;
		rca         = '0;
		ocr         = '0;
		cid[0]      = '0;
		cid[1]      = '0;
		csd[0]      = '0;
		csd[1]      = '0;
		wide        = 0;
		errors      = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_HOST_DATA_LINES) begin
			lines = val[3:0];
		end else begin
			window = val;
		end
	endfunction

	function bit is_sd();
		return ctype >= TYPE_SDV1 && ctype <= TYPE_SDHC;
	endfunction

	function logic [32:0] sectors();
		logic [7:0]  b5, b6, b7, b8, b9, b10;
		int unsigned shift;
		logic [63:0] count;
		b5  = csd[0][23:16];
		b6  = csd[0][15:8];
		b7  = csd[0][7:0];
		b8  = csd[1][63:56];
		b9  = csd[1][55:48];
		b10 = csd[1][47:40];
		if (ctype == TYPE_SDHC) begin
			count = 64'({b7[5:0], b8, b9}) + 64'd1;
			count = count << 10;
		end else begin
			shift = 32'(b5[3:0]) + 32'(b10[7]) + 2 * 32'(b9[1:0]) + 2;
			count = 64'(b8[7:6]) + (64'(b7) << 2) + (64'(b6[1:0]) << 10) + 64'd1;
			if (shift >= 9) begin
				count = count << (shift - 9);
			end else begin
				count = count >> (9 - shift);
			end
		end
		return count[32:0];
	endfunction

	function logic [19:0] bus_speed();
		logic [7:0]  ts;
		int unsigned mant [16];
		int unsigned unit;
		mant = '{0, 10, 12, 13, 15, 20, 25, 30, 35, 40, 45, 50, 55, 60, 70, 80};
		ts = csd[0][39:32];
		case (ts[2:0])
			3'd1: unit = 100;
			3'd2: unit = 1000;
			3'd3: unit = 10000;
			default: unit = 10;
		endcase
		return 20'(mant[ts[6:3]] * unit);
	endfunction

	function out_item_t status_reply(logic [1:0] act);
		out_item_t r;
		r              = '0;
		r.action       = act;
		r.wide_bus_ok  = wide;
		r.card_type    = ctype;
		r.card_address = rca;
		return r;
	endfunction

	function out_item_t cmd_reply(logic [5:0] c, logic [31:0] a, logic [2:0] rk, bit w);
		out_item_t r;
		r              = status_reply(ACT_ISSUE);
		r.cmd_index    = c;
		r.cmd_argument = a;
		r.resp_kind    = rk;
		r.wait_first   = w;
		return r;
	endfunction

	function out_item_t app_cmd(bit w);
		app_pending = 1;
		return cmd_reply(CMD_APP, {rca, 16'h0000}, RK_R1, w);
	endfunction

	function out_item_t fail_reply();
		ph          = PH_IDLE;
		app_pending = 0;
		return status_reply(ACT_FAILED);
	endfunction

	function out_item_t done_reply();
		out_item_t r;
		ph                 = PH_IDLE;
		app_pending        = 0;
		r                  = status_reply(ACT_DONE);
		r.capacity_sectors = sectors();
		r.max_speed        = bus_speed();
		return r;
	endfunction

	function out_item_t after_select();
		if (is_sd() && lines >= 4'd4) begin
			ph = PH_ACMD6;
			return app_cmd(1'b0);
		end
		return done_reply();
	endfunction

	function out_item_t card_ready(in_item_t b);
		ocr = b.resp_high[63:32];
		if (ph == PH_V2POLL) begin
			ctype = b.resp_high[62] ? TYPE_SDHC : TYPE_SDV2;
		end
		ph = PH_CMD2;
		return cmd_reply(CMD_ALL_CID, '0, RK_R2, 1'b0);
	endfunction

	function void note_beat(in_item_t b);
		out_item_t  r;
		logic [7:0] b0, b1, b2, b3;
		bit         bad;
		b0  = b.resp_high[63:56];
		b1  = b.resp_high[55:48];
		b2  = b.resp_high[47:40];
		b3  = b.resp_high[39:32];
		bad = b.cmd_failed;
		if (!b.kind) begin
			app_pending = 0;
			ctype       = TYPE_UNKNOWN;
			rca         = '0;
			ocr         = '0;
			cid[0]      = '0;
			cid[1]      = '0;
			csd[0]      = '0;
			csd[1]      = '0;
			wide        = 0;
			ph          = PH_CMD0;
			r = cmd_reply(CMD_GO_IDLE, '0, RK_NONE, 1'b0);
		end else begin
			case (ph)
				PH_CMD0: begin
					ph = PH_CMD8;
					r = cmd_reply(CMD_IF_COND, ARG_IF_COND, RK_R1, 1'b1);
				end
				PH_CMD8: begin
					ph = (!bad && b2[3:0] == 4'h1 && b3 == 8'hAA) ? PH_V2POLL : PH_PROBE;
					r = app_cmd(1'b0);
				end
				PH_PROBE: begin
					if (app_pending && !bad) begin
						app_pending = 0;
						r = cmd_reply(CMD_SD_OP_COND, ARG_OCR_DEF, RK_R3, 1'b0);
					end else if (bad) begin
						app_pending = 0;
						ctype = TYPE_MMC;
						ph = PH_MMCPOLL;
						r = cmd_reply(CMD_SEND_OP, ARG_OCR_DEF, RK_R3, 1'b0);
					end else begin
						ctype = TYPE_SDV1;
						ph = PH_V1POLL;
						r = app_cmd(1'b0);
					end
				end
				PH_V2POLL, PH_V1POLL: begin
					if (bad) begin
						r = fail_reply();
					end else if (app_pending) begin
						app_pending = 0;
						r = cmd_reply(CMD_SD_OP_COND,
							(ph == PH_V2POLL) ? (ARG_HCS | {8'h00, window}) : ARG_OCR_DEF,
							RK_R3, 1'b0);
					end else if (b0[7]) begin
						r = card_ready(b);
					end else begin
						r = app_cmd(1'b1);
					end
				end
				PH_MMCPOLL: begin
					if (bad) begin
						r = fail_reply();
					end else if (b0[7]) begin
						r = card_ready(b);
					end else begin
						r = cmd_reply(CMD_SEND_OP, ARG_OCR_DEF, RK_R3, 1'b1);
					end
				end
				PH_CMD2: begin
					if (bad) begin
						r = fail_reply();
					end else begin
						cid[0] = b.resp_high;
						cid[1] = b.resp_low;
						ph = PH_CMD3;
						r = cmd_reply(CMD_SEND_RCA, is_sd() ? 32'h0 : {16'd1, 16'h0000},
							RK_R6, 1'b0);
					end
				end
				PH_CMD3: begin
					rca = is_sd() ? {b0, b1} : 16'd1;
					if (bad) begin
						r = fail_reply();
					end else begin
						ph = PH_CMD9;
						r = cmd_reply(CMD_SEND_CSD, {rca, 16'h0000}, RK_R2, 1'b0);
					end
				end
				PH_CMD9: begin
					if (bad) begin
						r = fail_reply();
					end else begin
						csd[0] = b.resp_high;
						csd[1] = b.resp_low;
						ph = PH_CMD7;
						r = cmd_reply(CMD_SELECT, {rca, 16'h0000}, RK_R1B, 1'b0);
					end
				end
				PH_CMD7: begin
					if (bad) begin
						r = fail_reply();
					end else if (ctype != TYPE_SDHC) begin
						ph = PH_CMD16;
						r = cmd_reply(CMD_BLOCKLEN, ARG_BLOCKLEN, RK_R1, 1'b0);
					end else begin
						r = after_select();
					end
				end
				PH_CMD16: begin
					if (bad || (b0 & 8'hFD) != 0 || (b1 & 8'hF9) != 0) begin
						r = fail_reply();
					end else begin
						r = after_select();
					end
				end
				PH_ACMD6: begin
					if (app_pending) begin
						app_pending = 0;
						if (bad) begin
							r = done_reply();
						end else begin
							r = cmd_reply(CMD_BUS_WIDTH, ARG_WIDE_BUS, RK_R1, 1'b0);
						end
					end else begin
						if (!bad && (b0 & 8'hC0) == 0 && (b1 & 8'h58) == 0) begin
							wide = 1;
						end
						r = done_reply();
					end
				end
				default: begin
					ph = PH_IDLE;
					app_pending = 0;
					r = status_reply(ACT_IGNORED);
				end
			endcase
		end
		replies_due.push_back(r);
	endfunction

	function void field_check(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_reply(out_item_t got);
		out_item_t want;
		if (replies_due.size() == 0) begin
			$display("%0t: reply with none expected, got %h", $time, got);
			errors++;
			return;
		end
		want = replies_due.pop_front();
		field_check("action", want.action, got.action);
		field_check("cmd_index", want.cmd_index, got.cmd_index);
		field_check("cmd_argument", want.cmd_argument, got.cmd_argument);
		field_check("resp_kind", want.resp_kind, got.resp_kind);
		field_check("wait_first", want.wait_first, got.wait_first);
		field_check("wide_bus_ok", want.wide_bus_ok, got.wide_bus_ok);
		field_check("card_type", want.card_type, got.card_type);
		field_check("card_address", want.card_address, got.card_address);
		field_check("capacity_sectors", want.capacity_sectors, got.capacity_sectors);
		field_check("max_speed", want.max_speed, got.max_speed);
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 500000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	init_scoreboard sb = new();
	int             cycles = 0;
	int             burst_left;

	sd_card_init_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL sd_card_init_sequencer");
			$finish;
		end
	end

	function automatic in_item_t beat(bit k, bit f, logic [63:0] hi, logic [63:0] lo);
		in_item_t b;
		b.kind       = k;
		b.cmd_failed = f;
		b.resp_high  = hi;
		b.resp_low   = lo;
		return b;
	endfunction

	function automatic in_item_t any_beat();
		return beat($urandom_range(0, 1), $urandom_range(0, 1),
			{$urandom, $urandom}, {$urandom, $urandom});
	endfunction

	// Random content, shaped so that most card sessions get well past the probe.
	function automatic in_item_t next_beat();
		in_item_t b;
		b            = any_beat();
		b.kind       = 1'b1;
		b.cmd_failed = ($urandom_range(0, 19) == 0);
		case (sb.ph)
			PH_IDLE: b.kind = ($urandom_range(0, 7) == 0);
			PH_CMD8: begin
				b.cmd_failed = ($urandom_range(0, 7) == 0);
				if ($urandom_range(0, 3) != 0) begin
					b.resp_high[43:40] = 4'h1;
					b.resp_high[39:32] = 8'hAA;
				end
			end
			PH_PROBE: b.cmd_failed = ($urandom_range(0, 2) == 0);
			PH_CMD16: begin
				if ($urandom_range(0, 3) != 0) begin
					b.resp_high[63:56] &= 8'h02;
					b.resp_high[55:48] &= 8'h06;
				end
			end
			PH_ACMD6: begin
				if (!sb.app_pending && $urandom_range(0, 3) != 0) begin
					b.resp_high[63:56] &= 8'h3F;
					b.resp_high[55:48] &= 8'hA7;
				end
			end
			default: ;
		endcase
		if (sb.ph != PH_IDLE && $urandom_range(0, 59) == 0) begin
			b.kind = 1'b0;
		end
		if ($urandom_range(0, 29) == 0) begin
			b = any_beat();
		end
		return b;
	endfunction

	task automatic send_beat(in_item_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				in_data  <= any_beat();
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The receiver picks a stall pattern and keeps it for a while.
	initial begin
		int mode;
		int mode_left;
		int tick;
		out_ready = 1'b0;
		mode_left = 0;
		tick      = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_reply(out_data);
			end
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 128);
			end
			mode_left--;
			tick++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (tick % 4 == 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		int       counted;
		in_item_t b;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_write  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_HOST_DATA_LINES, 24'd4);
		write_reg(REG_OCR_WINDOW, 24'hFFFFFF);

		// A completion while idle is ignored, then an SDHC card with a wide bus.
		send_beat(beat(1'b1, 1'b1, '1, '1));
		send_beat(beat(1'b0, 1'b1, '1, '1));
		send_beat(beat(1'b1, 1'b1, '0, '0));
		send_beat(beat(1'b1, 1'b0, 64'h0000_01AA_0000_0000, '0));
		send_beat(beat(1'b1, 1'b0, '1, '1));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, 64'hC0FF_8000_0000_0000, '0));
		send_beat(beat(1'b1, 1'b0, '1, '1));
		send_beat(beat(1'b1, 1'b0, 64'hFFFF_0000_0000_0000, '0));
		send_beat(beat(1'b1, 1'b0, '1, '1));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));

		// An MMC card: the probe fails, polling repeats once, a zero CSD.
		send_beat(beat(1'b0, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b1, '0, '0));
		send_beat(beat(1'b1, 1'b1, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, 64'h8000_0000_0000_0000, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '1, '1));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));
		send_beat(beat(1'b1, 1'b0, '0, '0));

		for (int setting = 0; setting < 4; setting++) begin
			settle();
			case (setting)
				0: begin
					write_reg(REG_HOST_DATA_LINES, 24'(HOST_LINES_RESET));
					write_reg(REG_OCR_WINDOW, OCR_WINDOW_RESET);
				end
				1: begin
					write_reg(REG_HOST_DATA_LINES, 24'd0);
					write_reg(REG_OCR_WINDOW, 24'h000000);
				end
				2: begin
					write_reg(REG_HOST_DATA_LINES, 24'd15);
					write_reg(REG_OCR_WINDOW, 24'hFFFFFF);
				end
				default: begin
					write_reg(REG_HOST_DATA_LINES, 24'($urandom_range(0, 15)));
					write_reg(REG_OCR_WINDOW, 24'($urandom));
				end
			endcase
			counted = 0;
			while (counted < 250) begin
				b = next_beat();
				counted++;
				send_beat(b);
			end
		end
		settle();

		if (sb.errors == 0) begin
			$display("PASS sd_card_init_sequencer");
		end else begin
			$display("FAIL sd_card_init_sequencer");
		end
		$finish;
	end
endmodule
